@@ src/iopcr_pkg.sv @@
// ----------------------------------------------------------------------------
// iopcr_pkg
// Shared constants and types of the i/o processor command register unit:
// local store geometry, mode flag positions and the interface structs
// between the register file and the top-level pipeline.
// ----------------------------------------------------------------------------
package iopcr_pkg;

  localparam int PAGE_COUNT      = 25;
  localparam int WORDS_PER_PAGE  = 16;
  localparam int INTERRUPT_WORDS = 5;

  localparam int LS_DEPTH = PAGE_COUNT * WORDS_PER_PAGE;
  localparam int LS_AW    = $clog2(LS_DEPTH);

  localparam logic [4:0] DEV_LOCAL_STORE = 5'd8;
  localparam logic [5:0] SLICE_WRAP      = 6'd33;

  // mode flag bit positions
  localparam int MODE_BURST       = 0;
  localparam int MODE_DMA_BADPAR  = 1;
  localparam int MODE_DATA_BADPAR = 2;
  localparam int MODE_INT_TEST    = 3;

  localparam logic [3:0] MODE_RESET = 4'b0001;

  // result of one item as seen by the register file
  typedef struct packed {
    logic [31:0] cc;      // cc value unless keep or ls_rd
    logic        keep;    // tick: cc stays as left by the previous item
    logic        ls_rd;   // cc comes from the local store read
    logic [4:0]  page;
    logic [5:0]  slice;
    logic [3:0]  mode;
  } iopcr_res_t;

  // local store access wanted by the current item
  typedef struct packed {
    logic             rd;
    logic             wr;
    logic [LS_AW-1:0] addr;
  } iopcr_ls_req_t;

endpackage

@@ src/iopcr_ram.sv @@
// ----------------------------------------------------------------------------
// iopcr_ram
// Generic single-write, single-read synchronous ram with a registered read
// port that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module iopcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/iopcr_regs.sv @@
// ----------------------------------------------------------------------------
// iopcr_regs
// Command register file: slice and page sequencing, command decode, the
// enable, halt, discrete, status and interrupt registers, and the local
// store request of each item. State advances on every accepted item.
// ----------------------------------------------------------------------------
module iopcr_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    acc_i,
  input  logic                    op_i,
  input  logic [31:0]             cmd_i,
  input  logic [31:0]             data_i,
  input  logic [31:0]             din_i,
  output iopcr_pkg::iopcr_res_t    res_o,
  output iopcr_pkg::iopcr_ls_req_t req_o
);

  localparam logic [31:0] CMD_BURST_OFF     = 32'hc0030000;
  localparam logic [31:0] CMD_BURST_ON      = 32'hc1040000;
  localparam logic [31:0] CMD_DMA_BP_ON     = 32'hc1100000;
  localparam logic [31:0] CMD_DMA_BP_OFF    = 32'hc0100000;
  localparam logic [31:0] CMD_DATA_BP_ON    = 32'hc1200000;
  localparam logic [31:0] CMD_DATA_BP_OFF   = 32'hc0200000;
  localparam logic [31:0] CMD_XMIT_CLR      = 32'h84040000;
  localparam logic [31:0] CMD_XMIT_SET      = 32'h85040000;
  localparam logic [31:0] CMD_RECV_CLR      = 32'h84080000;
  localparam logic [31:0] CMD_RECV_SET      = 32'h85080000;
  localparam logic [31:0] CMD_DOUT_CLR      = 32'h84100000;
  localparam logic [31:0] CMD_DOUT_SET      = 32'h85100000;
  localparam logic [31:0] CMD_HALT_SET      = 32'h86200000;
  localparam logic [31:0] CMD_HALT_CLR      = 32'h87200000;
  localparam logic [31:0] CMD_MASTER_RESET  = 32'h84400000;
  localparam logic [31:0] CMD_TIMER_LOAD_A  = 32'h88040000;
  localparam logic [31:0] CMD_TIMER_LOAD_B  = 32'h88048000;
  localparam logic [31:0] CMD_LATCH_LOAD    = 32'h88080000;
  localparam logic [31:0] CMD_INT_TEST_ON   = 32'h88180000;
  localparam logic [31:0] CMD_INT_TEST_OFF  = 32'h88140000;
  localparam logic [31:0] CMD_BUSY_SET      = 32'h92040000;
  localparam logic [31:0] CMD_RD_XMIT       = 32'h04000000;
  localparam logic [31:0] CMD_RD_RECV       = 32'h40400000;
  localparam logic [31:0] CMD_RD_DOUT       = 32'h04080000;
  localparam logic [31:0] CMD_RD_HALT       = 32'h040c0000;
  localparam logic [31:0] CMD_RD_INT0       = 32'h08000000;
  localparam logic [31:0] CMD_RD_INT1       = 32'h08040000;
  localparam logic [31:0] CMD_RD_INT2       = 32'h08080000;
  localparam logic [31:0] CMD_RD_INT3       = 32'h080c0000;
  localparam logic [31:0] CMD_RD_INT4       = 32'h08100000;
  localparam logic [31:0] CMD_RD_RM_STATUS  = 32'h08140000;
  localparam logic [31:0] CMD_RD_DIN_A      = 32'h08180000;
  localparam logic [31:0] CMD_RD_DIN_B      = 32'h081c0000;
  localparam logic [31:0] CMD_RD_PROG_EXC   = 32'h10000000;
  localparam logic [31:0] CMD_RD_BUSY       = 32'h10040000;

  localparam logic [31:0] MR_PATTERN   = 32'hfffff800;
  localparam logic [31:0] TIMER_KEEP   = 32'hf000ffff;
  localparam logic [31:0] LATCH_KEEP   = 32'hffffafff;
  localparam logic [31:0] TIMER_FIELD  = 32'h00000fff;

  logic [5:0]  slice_q, slice_d, slice_inc;
  logic [4:0]  bce_q, bce_d, bce_base;
  logic [4:0]  page_q, page_d;
  logic [31:0] xmit_q, xmit_d;
  logic [31:0] recv_q, recv_d;
  logic [31:0] dout_q, dout_d;
  logic [31:0] halt_q, halt_d;
  logic [31:0] pexc_q, pexc_d;
  logic [31:0] busy_q, busy_d;
  logic [31:0] rms_q, rms_d;
  logic [31:0] int_q [iopcr_pkg::INTERRUPT_WORDS];
  logic [31:0] int_d [iopcr_pkg::INTERRUPT_WORDS];
  logic [3:0]  mode_q, mode_d;
  logic [31:0] cc_v;
  logic [4:0]  ls_idx;
  logic        ls_ok;
  logic        ls_dev;

  // bank*4 + word out of the data select field
  assign ls_idx = {1'b0, cmd_i[18:17], 2'b00} + {2'b00, cmd_i[16:14]};
  assign ls_ok  = ({1'b0, ls_idx} < 6'(iopcr_pkg::WORDS_PER_PAGE))
               && ({1'b0, page_q} < 6'(iopcr_pkg::PAGE_COUNT));
  assign ls_dev = !op_i && (cmd_i[29:25] == iopcr_pkg::DEV_LOCAL_STORE);

  assign req_o.rd   = ls_dev && cmd_i[31] && ls_ok;
  assign req_o.wr   = ls_dev && !cmd_i[31] && ls_ok;
  assign req_o.addr = iopcr_pkg::LS_AW'(page_q) * iopcr_pkg::LS_AW'(iopcr_pkg::WORDS_PER_PAGE)
                    + iopcr_pkg::LS_AW'(ls_idx);

  // slice sequencing
  always_comb begin
    slice_inc = slice_q + 6'd1;
    bce_base  = bce_q;
    if (slice_inc >= iopcr_pkg::SLICE_WRAP) begin
      slice_inc = '0;
      bce_base  = '0;
    end
  end

  always_comb begin
    slice_d = slice_q;
    bce_d   = bce_q;
    page_d  = page_q;
    xmit_d  = xmit_q;
    recv_d  = recv_q;
    dout_d  = dout_q;
    halt_d  = halt_q;
    pexc_d  = pexc_q;
    busy_d  = busy_q;
    rms_d   = rms_q;
    int_d   = int_q;
    mode_d  = mode_q;
    cc_v    = data_i;
    if (op_i) begin
      slice_d = slice_inc;
      if (slice_inc[1:0] != 2'b00) begin
        bce_d  = bce_base + 5'd1;
        page_d = bce_base + 5'd1;
      end else begin
        bce_d  = bce_base;
        page_d = '0;
      end
    end else begin
      unique case (cmd_i)
        CMD_BURST_OFF:    mode_d[iopcr_pkg::MODE_BURST] = 1'b0;
        CMD_BURST_ON:     mode_d[iopcr_pkg::MODE_BURST] = 1'b1;
        CMD_DMA_BP_ON:    mode_d[iopcr_pkg::MODE_DMA_BADPAR] = 1'b1;
        CMD_DMA_BP_OFF:   mode_d[iopcr_pkg::MODE_DMA_BADPAR] = 1'b0;
        CMD_DATA_BP_ON:   mode_d[iopcr_pkg::MODE_DATA_BADPAR] = 1'b1;
        CMD_DATA_BP_OFF:  mode_d[iopcr_pkg::MODE_DATA_BADPAR] = 1'b0;
        CMD_XMIT_CLR:     xmit_d = xmit_q & ~data_i;
        CMD_XMIT_SET:     xmit_d = xmit_q | data_i;
        CMD_RECV_CLR:     recv_d = recv_q & ~data_i;
        CMD_RECV_SET:     recv_d = recv_q | data_i;
        CMD_DOUT_CLR:     dout_d = dout_q & ~data_i;
        CMD_DOUT_SET:     dout_d = dout_q | data_i;
        CMD_HALT_SET:     halt_d = halt_q | data_i;
        CMD_HALT_CLR:     halt_d = halt_q & ~data_i;
        CMD_MASTER_RESET: begin
          pexc_d = MR_PATTERN;
          busy_d = '0;
          halt_d = MR_PATTERN;
          xmit_d = '0;
          recv_d = '0;
          dout_d = '0;
        end
        CMD_TIMER_LOAD_A, CMD_TIMER_LOAD_B: begin
          rms_d = (rms_q & TIMER_KEEP) | ((data_i & TIMER_FIELD) << 16);
        end
        CMD_LATCH_LOAD: begin
          rms_d = rms_q & LATCH_KEEP;
          rms_d[12] = data_i[1];
          rms_d[14] = data_i[0];
        end
        CMD_INT_TEST_ON: begin
          mode_d[iopcr_pkg::MODE_INT_TEST] = 1'b1;
          int_d[0] = '1;
          int_d[1] = '1;
          int_d[3] = '1;
          int_d[4] = '1;
        end
        CMD_INT_TEST_OFF: mode_d[iopcr_pkg::MODE_INT_TEST] = 1'b0;
        CMD_BUSY_SET:     busy_d = busy_q | 32'd1;
        CMD_RD_XMIT:      cc_v = xmit_q;
        CMD_RD_RECV:      cc_v = recv_q;
        CMD_RD_DOUT:      cc_v = dout_q;
        CMD_RD_HALT:      cc_v = halt_q;
        CMD_RD_INT0: begin
          cc_v = int_q[0];
          int_d[0] = '0;
        end
        CMD_RD_INT1: begin
          cc_v = int_q[1];
          int_d[1] = '0;
        end
        CMD_RD_INT2: begin
          cc_v = int_q[2];
          int_d[2] = '0;
        end
        CMD_RD_INT3: begin
          cc_v = int_q[3];
          int_d[3] = '0;
        end
        CMD_RD_INT4: begin
          cc_v = int_q[4];
          int_d[4] = '0;
        end
        CMD_RD_RM_STATUS:             cc_v = rms_q;
        CMD_RD_DIN_A, CMD_RD_DIN_B:   cc_v = din_i;
        CMD_RD_PROG_EXC:              cc_v = pexc_q;
        CMD_RD_BUSY:                  cc_v = busy_q;
        default: ;
      endcase
      // out-of-range local store reads give zero
      if (ls_dev && cmd_i[31] && !ls_ok) begin
        cc_v = '0;
      end
    end
  end

  assign res_o.cc    = cc_v;
  assign res_o.keep  = op_i;
  assign res_o.ls_rd = req_o.rd;
  assign res_o.page  = page_d;
  assign res_o.slice = slice_d;
  assign res_o.mode  = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= '0;
      bce_q   <= '0;
      page_q  <= '0;
      xmit_q  <= '0;
      recv_q  <= '0;
      dout_q  <= '0;
      halt_q  <= '0;
      pexc_q  <= '0;
      busy_q  <= '0;
      rms_q   <= '0;
      for (int i = 0; i < iopcr_pkg::INTERRUPT_WORDS; i++) begin
        int_q[i] <= '0;
      end
      mode_q  <= iopcr_pkg::MODE_RESET;
    end else if (acc_i) begin
      slice_q <= slice_d;
      bce_q   <= bce_d;
      page_q  <= page_d;
      xmit_q  <= xmit_d;
      recv_q  <= recv_d;
      dout_q  <= dout_d;
      halt_q  <= halt_d;
      pexc_q  <= pexc_d;
      busy_q  <= busy_d;
      rms_q   <= rms_d;
      int_q   <= int_d;
      mode_q  <= mode_d;
    end
  end

endmodule

@@ src/io_processor_command_register_unit_top.sv @@
// ----------------------------------------------------------------------------
// io_processor_command_register_unit_top
// I/O processor command register unit: cpu commands and time-slice ticks
// update the register file, the local store of every page sits in a ram.
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   command, data, discrete_in_a            operation
//   m_axis    out  cc_data, current_page, slice_number,    -
//                  dma_burst_on, dma_addr_bad_parity,
//                  data_in_bad_parity, interrupt_test_mode
//
// one item per cycle while the output is not stalled and no clearing pass runs;
// an accepted item passes the local store read stage, then the output register.
// after reset a clearing pass zeroes all LS_DEPTH (400) local store words,
// with s_axis_tready_o held low throughout.
// a stalled output holds one result and one more item in the read stage;
// the input then stalls until the output is taken.
// ----------------------------------------------------------------------------
module io_processor_command_register_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // command[31:0], data[63:32], discrete_in_a[95:64]
  input  logic        s_axis_tuser_i,   // operation
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o    // cc_data[31:0], current_page[36:32],
                                        // slice_number[42:37], dma_burst_on[43],
                                        // dma_addr_bad_parity[44],
                                        // data_in_bad_parity[45],
                                        // interrupt_test_mode[46], zero[47]
);

  localparam int AW = iopcr_pkg::LS_AW;

  iopcr_pkg::iopcr_res_t    res;
  iopcr_pkg::iopcr_ls_req_t req;
  iopcr_pkg::iopcr_res_t    s1_q;
  logic                     s1_v_q;
  logic                     out_v_q;
  logic [47:0]              out_q;
  logic [31:0]              cc_q;
  logic [31:0]              cc_res;
  logic                     clr_busy_q;
  logic [AW-1:0]            clr_cnt_q;
  logic                     acc;
  logic                     s1_move;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [31:0]              ram_wdata;
  logic                     ram_re;
  logic [31:0]              ram_rdata;

  assign s1_move         = s1_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !clr_busy_q && (!s1_v_q || s1_move);
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  iopcr_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .op_i   (s_axis_tuser_i),
    .cmd_i  (s_axis_tdata_i[31:0]),
    .data_i (s_axis_tdata_i[63:32]),
    .din_i  (s_axis_tdata_i[95:64]),
    .res_o  (res),
    .req_o  (req)
  );

  // writes go in at accept, so a read one item later already sees them
  assign ram_we    = clr_busy_q || (acc && req.wr);
  assign ram_waddr = clr_busy_q ? clr_cnt_q : req.addr;
  assign ram_wdata = clr_busy_q ? 32'd0 : s_axis_tdata_i[63:32];
  assign ram_re    = acc && req.rd;

  iopcr_ram #(
    .WIDTH (32),
    .DEPTH (iopcr_pkg::LS_DEPTH)
  ) u_ls_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (req.addr),
    .rdata_o (ram_rdata)
  );

  // a tick keeps cc as the previous item left it
  always_comb begin
    if (s1_q.ls_rd) begin
      cc_res = ram_rdata;
    end else if (s1_q.keep) begin
      cc_res = cc_q;
    end else begin
      cc_res = s1_q.cc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == AW'(iopcr_pkg::LS_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      cc_q    <= '0;
    end else begin
      if (acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        out_v_q <= 1'b1;
        cc_q    <= cc_res;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= res;
    end
    if (s1_move) begin
      out_q <= {1'b0,
                s1_q.mode[iopcr_pkg::MODE_INT_TEST],
                s1_q.mode[iopcr_pkg::MODE_DATA_BADPAR],
                s1_q.mode[iopcr_pkg::MODE_DMA_BADPAR],
                s1_q.mode[iopcr_pkg::MODE_BURST],
                s1_q.slice, s1_q.page, cc_res};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q;

  // the ram never gets a read and a write in the same cycle
  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("local store read and write collide");

  // a local store read lands in the read stage in the cycle after it is accepted
  a_rd_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && req.rd) |=> (s1_v_q && s1_q.ls_rd))
    else $error("local store read lost its stage");

  // nothing is in flight during the clearing pass
  a_clr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s1_v_q && !out_v_q))
    else $error("item in flight during clearing pass");

  // page and slice stay in range
  a_page_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ({1'b0, out_q[36:32]} < 6'(iopcr_pkg::PAGE_COUNT)))
    else $error("page out of range");

  a_slice_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q[42:37] < iopcr_pkg::SLICE_WRAP))
    else $error("slice out of range");

endmodule
